### rtl/core/hkre_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hkre_pkg
// Shared types and constants for the keyboard report to key event decoder.
// ----------------------------------------------------------------------------
package hkre_pkg;

  localparam int KEY_SLOTS_DEF = 6;
  localparam int REPORT_BYTES  = 9;

  // event kinds
  localparam logic [3:0] EV_CHAR        = 4'd0;
  localparam logic [3:0] EV_RUBOUT      = 4'd1;
  localparam logic [3:0] EV_NEWLINE     = 4'd2;
  localparam logic [3:0] EV_PAN_UP      = 4'd3;
  localparam logic [3:0] EV_PAN_DOWN    = 4'd4;
  localparam logic [3:0] EV_NEW         = 4'd5;
  localparam logic [3:0] EV_MORE        = 4'd6;
  localparam logic [3:0] EV_LEFT        = 4'd7;
  localparam logic [3:0] EV_RIGHT       = 4'd8;
  localparam logic [3:0] EV_MENU        = 4'd9;
  localparam logic [3:0] EV_ERASE       = 4'd10;

  // modifier byte masks
  localparam logic [7:0] MOD_CTRL_MASK  = 8'h11;
  localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;

  localparam logic [6:0] DIGIT_PLAIN [10] = '{
    7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30
  };
  localparam logic [6:0] DIGIT_SHIFT [10] = '{
    7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29
  };

  typedef struct packed {
    logic       valid;
    logic [3:0] kind;
    logic [6:0] chr;
  } hkre_event_t;

endpackage : hkre_pkg
`default_nettype wire

### rtl/core/hid_keyboard_report_to_key_events_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hid_keyboard_report_to_key_events_core
// Boot keyboard report decoder: one report in, up to KEY_SLOTS key events out.
//
// Input channel (in_*): one report per transfer, length plus nine bytes.
// Output channel (out_*): one key event per transfer, in key slot order;
// out_last_of_report marks the final event of a report.
// A report is decoded in the cycle it is taken: the key slots go through
// KEY_SLOTS decode lanes in parallel, the stored key set and caps lock flag
// are updated, and the lane results are parked in a pending buffer.
// From the pending buffer each event passes through the output register;
// events leave one per cycle while out_stall is low. The next report is
// taken in the cycle its predecessor's last event moves to the output
// register. Reports that give no event (short, all-zero, unchanged or
// unknown keys) add nothing to the pending buffer.
// Reset clears the stored key set, caps lock and all pending events.
// While out_stall is high with an event on the output, the output holds
// and the pending buffer waits; in_stall is high while events stay pending.
// ----------------------------------------------------------------------------
module hid_keyboard_report_to_key_events_core #(
  parameter int KEY_SLOTS = hkre_pkg::KEY_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_report_length,
  input  logic [7:0] in_report_byte_0,
  input  logic [7:0] in_report_byte_1,
  input  logic [7:0] in_report_byte_2,
  input  logic [7:0] in_report_byte_3,
  input  logic [7:0] in_report_byte_4,
  input  logic [7:0] in_report_byte_5,
  input  logic [7:0] in_report_byte_6,
  input  logic [7:0] in_report_byte_7,
  input  logic [7:0] in_report_byte_8,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_event_kind,
  output logic [6:0] out_char_code,
  output logic       out_last_of_report
);
  import hkre_pkg::*;

  logic [7:0] rbytes [REPORT_BYTES];
  logic [3:0] len_c, len_eff;
  logic       has_id;
  logic [7:0] mod_byte;
  logic       ctrl, shift;
  logic [7:0] slot [KEY_SLOTS];
  logic       any_key, changed;
  logic [4:0] byte_idx [KEY_SLOTS];

  logic [7:0] prev_keys_r [KEY_SLOTS];
  logic [7:0] prev_keys_nxt [KEY_SLOTS];
  logic       caps_r, caps_nxt;

  logic [KEY_SLOTS:0]   caps_chain;
  logic [KEY_SLOTS-1:0] lane_caps;
  hkre_event_t [KEY_SLOTS-1:0] lane_ev;

  logic can_take, accept, load;

  assign rbytes[0] = in_report_byte_0;
  assign rbytes[1] = in_report_byte_1;
  assign rbytes[2] = in_report_byte_2;
  assign rbytes[3] = in_report_byte_3;
  assign rbytes[4] = in_report_byte_4;
  assign rbytes[5] = in_report_byte_5;
  assign rbytes[6] = in_report_byte_6;
  assign rbytes[7] = in_report_byte_7;
  assign rbytes[8] = in_report_byte_8;

  assign len_c   = (in_report_length > 4'(REPORT_BYTES)) ? 4'(REPORT_BYTES)
                                                         : in_report_length;
  assign has_id  = (len_c >= 4'd4) && (rbytes[0] >= 8'd1) && (rbytes[0] <= 8'd4)
                   && (rbytes[2] == 8'h00);
  assign len_eff = len_c - {3'b000, has_id};
  assign mod_byte = has_id ? rbytes[1] : rbytes[0];
  assign ctrl    = (mod_byte & MOD_CTRL_MASK) != 8'h00;
  assign shift   = (mod_byte & MOD_SHIFT_MASK) != 8'h00;

  // key slot k sits at byte 2+k after the report ID, if inside the length
  always_comb begin
    any_key = 1'b0;
    changed = 1'b0;
    for (int k = 0; k < KEY_SLOTS; k++) begin
      byte_idx[k] = 5'(k + 2) + {4'b0000, has_id};
      slot[k] = 8'h00;
      if ((5'(k + 2) < {1'b0, len_eff}) && (byte_idx[k] < 5'(REPORT_BYTES))) begin
        slot[k] = rbytes[byte_idx[k][3:0]];
      end
      if (slot[k] != 8'h00) begin
        any_key = 1'b1;
      end
      if (slot[k] != prev_keys_r[k]) begin
        changed = 1'b1;
      end
    end
  end

  assign caps_chain[0] = caps_r;

  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
    hkre_lane u_lane (
      .key      (slot[g]),
      .ctrl     (ctrl),
      .shift    (shift),
      .caps     (caps_chain[g]),
      .ev       (lane_ev[g]),
      .caps_key (lane_caps[g])
    );
    assign caps_chain[g+1] = caps_chain[g] ^ lane_caps[g];
  end

  assign accept   = in_valid && can_take;
  assign in_stall = !can_take;
  assign load     = accept && (len_c >= 4'd3) && any_key && changed;

  always_comb begin
    prev_keys_nxt = prev_keys_r;
    caps_nxt      = caps_r;
    if (accept && len_c >= 4'd3) begin
      if (!any_key) begin
        for (int k = 0; k < KEY_SLOTS; k++) begin
          prev_keys_nxt[k] = 8'h00;
        end
      end else if (changed) begin
        prev_keys_nxt = slot;
        caps_nxt      = caps_chain[KEY_SLOTS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < KEY_SLOTS; k++) begin
        prev_keys_r[k] <= 8'h00;
      end
      caps_r <= 1'b0;
    end else begin
      prev_keys_r <= prev_keys_nxt;
      caps_r      <= caps_nxt;
    end
  end

  hkre_merge #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_merge (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (load),
    .load_ev            (lane_ev),
    .can_take           (can_take),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_kind     (out_event_kind),
    .out_char_code      (out_char_code),
    .out_last_of_report (out_last_of_report)
  );

endmodule : hid_keyboard_report_to_key_events_core
`default_nettype wire

### rtl/core/hkre_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hkre_lane
// Decodes one key slot into an event; flags the caps lock key.
// ----------------------------------------------------------------------------
module hkre_lane (
  input  logic [7:0]          key,
  input  logic                ctrl,
  input  logic                shift,
  input  logic                caps,
  output hkre_pkg::hkre_event_t ev,
  output logic                caps_key
);
  import hkre_pkg::*;

  logic [3:0] digit_idx;
  logic       upper;

  assign digit_idx = 4'(key - 8'h1E);
  assign upper     = shift ^ caps;
  assign caps_key  = (key == 8'h39);

  always_comb begin
    ev.valid = 1'b1;
    ev.kind  = EV_CHAR;
    ev.chr   = 7'h00;
    if (key == 8'h00) begin
      ev.valid = 1'b0;
    end else if (ctrl && key == 8'h11) begin
      ev.kind = EV_NEW;
    end else if (ctrl && key == 8'h10) begin
      ev.kind = EV_MORE;
    end else if (ctrl && key == 8'h07) begin
      ev.chr = 7'h04;                    // ctrl-D
    end else begin
      case (key) inside
        8'h52, 8'h4B: ev.kind = EV_PAN_DOWN;
        8'h51, 8'h4E: ev.kind = EV_PAN_UP;
        8'h4A:        ev.kind = EV_MENU;
        8'h4C:        ev.kind = EV_ERASE;
        8'h39:        ev.valid = 1'b0;   // caps lock, toggled in the core via caps_key
        8'h50:        ev.kind = EV_LEFT;
        8'h4F:        ev.kind = EV_RIGHT;
        8'h28:        ev.kind = EV_NEWLINE;
        8'h2A:        ev.kind = EV_RUBOUT;
        default: begin
          if (ctrl) begin
            ev.valid = 1'b0;
          end else begin
            case (key) inside
              [8'h04:8'h1D]: ev.chr = upper ? 7'(key + 8'h3D) : 7'(key + 8'h5D);
              [8'h1E:8'h27]: ev.chr = shift ? DIGIT_SHIFT[digit_idx]
                                            : DIGIT_PLAIN[digit_idx];
              8'h2C: ev.chr = 7'h20;
              8'h2D: ev.chr = shift ? 7'h5F : 7'h2D;
              8'h2E: ev.chr = shift ? 7'h2B : 7'h3D;
              8'h2F: ev.chr = shift ? 7'h7B : 7'h5B;
              8'h30: ev.chr = shift ? 7'h7D : 7'h5D;
              8'h31: ev.chr = shift ? 7'h7C : 7'h5C;
              8'h33: ev.chr = shift ? 7'h3A : 7'h3B;
              8'h34: ev.chr = shift ? 7'h22 : 7'h27;
              8'h35: ev.chr = shift ? 7'h7E : 7'h60;
              8'h36: ev.chr = shift ? 7'h3C : 7'h2C;
              8'h37: ev.chr = shift ? 7'h3E : 7'h2E;
              8'h38: ev.chr = shift ? 7'h3F : 7'h2F;
              default: ev.valid = 1'b0;
            endcase
          end
        end
      endcase
    end
  end

endmodule : hkre_lane
`default_nettype wire

### rtl/core/hkre_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hkre_merge
// Holds the lane results of one report and sends them out in slot order,
// one per cycle while the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module hkre_merge #(
  parameter int KEY_SLOTS = hkre_pkg::KEY_SLOTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  hkre_pkg::hkre_event_t [KEY_SLOTS-1:0] load_ev,
  output logic                                  can_take,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [3:0]                            out_event_kind,
  output logic [6:0]                            out_char_code,
  output logic                                  out_last_of_report
);
  import hkre_pkg::*;

  logic [KEY_SLOTS-1:0] pend_vld_r, pend_vld_nxt;
  hkre_event_t [KEY_SLOTS-1:0] pend_ev_r;
  logic [KEY_SLOTS-1:0] rest;
  logic [3:0] sel_kind;
  logic [6:0] sel_chr;
  logic       found;
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] kind_r;
  logic [6:0] chr_r;
  logic       last_r;
  logic       out_load, emit;

  // lowest pending slot wins
  always_comb begin
    found    = 1'b0;
    sel_kind = EV_CHAR;
    sel_chr  = 7'h00;
    rest     = pend_vld_r;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (pend_vld_r[i] && !found) begin
        found    = 1'b1;
        sel_kind = pend_ev_r[i].kind;
        sel_chr  = pend_ev_r[i].chr;
        rest[i]  = 1'b0;
      end
    end
  end

  assign out_load = !out_valid_r || !out_stall;
  assign emit     = found && out_load;
  assign can_take = !found || (emit && rest == '0);

  always_comb begin
    pend_vld_nxt  = pend_vld_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        pend_vld_nxt[i] = load_ev[i].valid;
      end
    end else if (emit) begin
      pend_vld_nxt = rest;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_load) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (load) begin
      pend_ev_r <= load_ev;
    end
    if (emit) begin
      kind_r <= sel_kind;
      chr_r  <= sel_chr;
      last_r <= (rest == '0);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_kind     = kind_r;
  assign out_char_code      = chr_r;
  assign out_last_of_report = last_r;

endmodule : hkre_merge
`default_nettype wire
